[rtl/csc_pkg.sv]
// Shared types, codes and helpers of the charging-point session controller.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package csc_pkg;

	localparam int HOLD_W     = 16;
	localparam int CUR_W      = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CODE_W     = 4;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DENY_HOLD  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AUTH_HOLD  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STAGE_HOLD = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_HOLD = 8'd3;

	localparam logic [HOLD_W-1:0] DENY_HOLD_RST  = 16'd1000;
	localparam logic [HOLD_W-1:0] AUTH_HOLD_RST  = 16'd1100;
	localparam logic [HOLD_W-1:0] STAGE_HOLD_RST = 16'd5000;
	localparam logic [HOLD_W-1:0] SHORT_HOLD_RST = 16'd10;

	// Main session state, one-hot
	typedef enum logic [9:0] {
		ST_UNKNOWN = 10'b00_0000_0001,
		ST_INIT    = 10'b00_0000_0010,
		ST_IDLE    = 10'b00_0000_0100,
		ST_PREP    = 10'b00_0000_1000,
		ST_PRECHG  = 10'b00_0001_0000,
		ST_CHARGE  = 10'b00_0010_0000,
		ST_STOP    = 10'b00_0100_0000,
		ST_FINISH  = 10'b00_1000_0000,
		ST_WAIT    = 10'b01_0000_0000,
		ST_ERROR   = 10'b10_0000_0000
	} main_state_t;

	// Reported state codes
	localparam logic [CODE_W-1:0] CODE_UNKNOWN = 4'd0;
	localparam logic [CODE_W-1:0] CODE_INIT    = 4'd1;
	localparam logic [CODE_W-1:0] CODE_IDLE    = 4'd2;
	localparam logic [CODE_W-1:0] CODE_PREP    = 4'd3;
	localparam logic [CODE_W-1:0] CODE_PRECHG  = 4'd4;
	localparam logic [CODE_W-1:0] CODE_CHARGE  = 4'd5;
	localparam logic [CODE_W-1:0] CODE_STOP    = 4'd6;
	localparam logic [CODE_W-1:0] CODE_FINISH  = 4'd7;
	localparam logic [CODE_W-1:0] CODE_WAIT    = 4'd8;
	localparam logic [CODE_W-1:0] CODE_ERROR   = 4'd9;

	typedef enum logic [3:0] {
		SS_START     = 4'd0,
		SS_AUTH_IDLE = 4'd1,
		SS_PREP      = 4'd2,
		SS_RELAY_ON  = 4'd3,
		SS_SENSED    = 4'd4,
		SS_NO_CURR   = 4'd5,
		SS_EV_DONE   = 4'd6,
		SS_RELAY_OFF = 4'd7,
		SS_AUTH_RUN  = 4'd8,
		SS_USER_STOP = 4'd9,
		SS_EV_FINAL  = 4'd10
	} sub_step_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_READER = 2'd1,
		EV_DENIED = 2'd2,
		EV_AUTH   = 2'd3
	} rfid_ev_t;

	typedef enum logic [3:0] {
		PIX_BLANK   = 4'd0,
		PIX_IDLE    = 4'd1,
		PIX_DENIED  = 4'd2,
		PIX_AUTH    = 4'd3,
		PIX_PREP    = 4'd4,
		PIX_PRECHG  = 4'd5,
		PIX_CHARGE  = 4'd6,
		PIX_STOPPED = 4'd7,
		PIX_FINISH  = 4'd8
	} pixel_t;

	typedef enum logic [1:0] {
		BUZ_OFF    = 2'd0,
		BUZ_DENIED = 2'd1,
		BUZ_AUTH   = 2'd2
	} buzzer_t;

	typedef struct packed {
		main_state_t        main;
		main_state_t        resume;
		sub_step_t          sub;
		logic [HOLD_W-1:0]  wait_rem;
		rfid_ev_t           pending;
		pixel_t             pixel;
		buzzer_t            buzzer;
		logic               relay;
		logic               scan;
	} csc_state_t;

	typedef struct packed {
		logic [HOLD_W-1:0] deny;
		logic [HOLD_W-1:0] auth;
		logic [HOLD_W-1:0] stage;
		logic [HOLD_W-1:0] brief;
	} csc_holds_t;

	// Map the one-hot main state to its reported code
	function automatic logic [CODE_W-1:0] state_code(main_state_t s);
		logic [CODE_W-1:0] c;
		case (s)
			ST_UNKNOWN: c = CODE_UNKNOWN;
			ST_INIT:    c = CODE_INIT;
			ST_IDLE:    c = CODE_IDLE;
			ST_PREP:    c = CODE_PREP;
			ST_PRECHG:  c = CODE_PRECHG;
			ST_CHARGE:  c = CODE_CHARGE;
			ST_STOP:    c = CODE_STOP;
			ST_FINISH:  c = CODE_FINISH;
			ST_WAIT:    c = CODE_WAIT;
			ST_ERROR:   c = CODE_ERROR;
			default:    c = CODE_UNKNOWN;
		endcase
		return c;
	endfunction

endpackage

[rtl/csc_ifs.sv]
// Valid/ready channel interfaces: tick input, result output, register writes.
// Depends on csc_pkg.
`timescale 1ns / 1ps

interface csc_in_if import csc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              rfid_event;
	logic signed [CUR_W-1:0] load_current;

	modport source (output valid, rfid_event, load_current, input ready);
	modport sink (input valid, rfid_event, load_current, output ready);
endinterface

interface csc_out_if import csc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              relay_on;
	logic              scan_enable;
	logic [3:0]        pixel_code;
	logic [1:0]        buzzer_code;
	logic [CODE_W-1:0] session_state;
	logic              pixel_restart;

	modport source (output valid, relay_on, scan_enable, pixel_code, buzzer_code,
		session_state, pixel_restart, input ready);
	modport sink (input valid, relay_on, scan_enable, pixel_code, buzzer_code,
		session_state, pixel_restart, output ready);
endinterface

interface csc_cfg_if import csc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [HOLD_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/csc_step.sv]
// Next-state logic of the session controller for one millisecond tick.
// Depends on csc_pkg.
`timescale 1ns / 1ps

module csc_step import csc_pkg::*; (
	input  csc_state_t              cur_st,
	input  csc_holds_t              holds,
	input  logic [1:0]              rfid_event,
	input  logic signed [CUR_W-1:0] load_current,
	output csc_state_t              nxt_st,
	output logic                    restart
);

	logic     cur_zero;
	logic     cur_pos;
	rfid_ev_t pend;

	assign cur_zero = (load_current == '0);
	assign cur_pos  = !cur_zero && !load_current[CUR_W-1];
	// Latch a new reader status before evaluating the state
	assign pend     = (rfid_event != EV_NONE) ? rfid_ev_t'(rfid_event) : cur_st.pending;

	always_comb begin
		nxt_st         = cur_st;
		nxt_st.pending = pend;
		restart        = 1'b0;
		case (cur_st.main)
			ST_ERROR: begin
			end
			ST_UNKNOWN: begin
				if (pend == EV_READER)
					nxt_st.main = ST_INIT;
			end
			ST_INIT: begin
				nxt_st.main  = ST_IDLE;
				nxt_st.relay = 1'b0;
				nxt_st.scan  = 1'b1;
				nxt_st.sub   = SS_START;
			end
			ST_IDLE: begin
				if (pend == EV_DENIED) begin
					nxt_st.pixel    = PIX_DENIED;
					nxt_st.buzzer   = BUZ_DENIED;
					nxt_st.resume   = ST_IDLE;
					nxt_st.main     = ST_WAIT;
					nxt_st.wait_rem = holds.deny;
					nxt_st.pending  = EV_NONE;
				end else if (pend == EV_AUTH) begin
					nxt_st.pixel    = PIX_AUTH;
					nxt_st.buzzer   = BUZ_AUTH;
					nxt_st.sub      = SS_AUTH_IDLE;
					nxt_st.resume   = ST_PREP;
					nxt_st.main     = ST_WAIT;
					nxt_st.wait_rem = holds.auth;
					nxt_st.pending  = EV_NONE;
				end else begin
					nxt_st.pixel = PIX_IDLE;
				end
			end
			ST_PREP: begin
				nxt_st.pixel    = PIX_PREP;
				nxt_st.scan     = 1'b0;
				nxt_st.sub      = SS_PREP;
				nxt_st.resume   = ST_PRECHG;
				nxt_st.main     = ST_WAIT;
				nxt_st.wait_rem = holds.stage;
				nxt_st.pending  = EV_NONE;
			end
			ST_PRECHG: begin
				if (cur_st.sub == SS_PREP) begin
					// Close the contactor and give the load time to draw current
					nxt_st.pixel    = PIX_PRECHG;
					nxt_st.sub      = SS_RELAY_ON;
					nxt_st.resume   = ST_PRECHG;
					nxt_st.main     = ST_WAIT;
					nxt_st.wait_rem = holds.stage;
					nxt_st.pending  = EV_NONE;
					nxt_st.relay    = 1'b1;
				end else if (cur_st.sub == SS_RELAY_ON) begin
					if (!cur_zero) begin
						nxt_st.sub      = SS_SENSED;
						nxt_st.resume   = ST_CHARGE;
						nxt_st.main     = ST_WAIT;
						nxt_st.wait_rem = holds.brief;
						nxt_st.pending  = EV_NONE;
						restart         = 1'b1;
					end else begin
						nxt_st.relay = 1'b0;
						nxt_st.main  = ST_INIT;
						nxt_st.sub   = SS_NO_CURR;
					end
				end
			end
			ST_CHARGE: begin
				nxt_st.scan = 1'b1;
				if (cur_zero) begin
					if (cur_st.sub == SS_SENSED) begin
						nxt_st.sub      = SS_EV_DONE;
						nxt_st.pixel    = PIX_PRECHG;
						nxt_st.resume   = ST_CHARGE;
						nxt_st.main     = ST_WAIT;
						nxt_st.wait_rem = holds.stage;
					end else if (cur_st.sub == SS_EV_DONE) begin
						nxt_st.relay    = 1'b0;
						nxt_st.sub      = SS_RELAY_OFF;
						nxt_st.resume   = ST_FINISH;
						nxt_st.main     = ST_WAIT;
						nxt_st.wait_rem = holds.brief;
					end
				end else if (cur_pos) begin
					nxt_st.pixel = PIX_CHARGE;
					if (pend == EV_DENIED) begin
						nxt_st.pixel    = PIX_DENIED;
						nxt_st.buzzer   = BUZ_DENIED;
						nxt_st.resume   = ST_CHARGE;
						nxt_st.main     = ST_WAIT;
						nxt_st.wait_rem = holds.deny;
						nxt_st.pending  = EV_NONE;
					end else if (pend == EV_AUTH) begin
						// Card presented while charging: user stop
						nxt_st.sub      = SS_AUTH_RUN;
						restart         = 1'b1;
						nxt_st.pixel    = PIX_AUTH;
						nxt_st.buzzer   = BUZ_AUTH;
						nxt_st.resume   = ST_STOP;
						nxt_st.main     = ST_WAIT;
						nxt_st.wait_rem = holds.auth;
						nxt_st.pending  = EV_NONE;
						nxt_st.relay    = 1'b0;
					end
				end
			end
			ST_STOP: begin
				nxt_st.pixel = PIX_STOPPED;
				nxt_st.scan  = 1'b0;
				if (cur_st.sub == SS_AUTH_RUN) begin
					nxt_st.sub      = SS_USER_STOP;
					nxt_st.resume   = ST_INIT;
					nxt_st.main     = ST_WAIT;
					nxt_st.wait_rem = holds.stage;
				end
			end
			ST_FINISH: begin
				nxt_st.pixel = PIX_FINISH;
				if (cur_st.sub == SS_RELAY_OFF) begin
					nxt_st.sub      = SS_EV_FINAL;
					nxt_st.resume   = ST_INIT;
					nxt_st.main     = ST_WAIT;
					nxt_st.wait_rem = holds.stage;
				end
			end
			ST_WAIT: begin
				// Count the hold down, then blank the indicators and resume
				if (cur_st.wait_rem > HOLD_W'(1)) begin
					nxt_st.wait_rem = cur_st.wait_rem - HOLD_W'(1);
				end else begin
					nxt_st.wait_rem = '0;
					nxt_st.main     = cur_st.resume;
					nxt_st.pixel    = PIX_BLANK;
					nxt_st.buzzer   = BUZ_OFF;
				end
			end
			default: begin
				nxt_st.main = ST_UNKNOWN;
			end
		endcase
	end

endmodule

[rtl/charge_session_controller_top.sv]
// Charging-point session controller: input register, tick logic, result register.
// Depends on csc_pkg, csc_ifs and csc_step.
// A tick passes through the input register, the tick logic and the result register.
// Throughput: one tick per cycle while the result side is ready.
// Reset (arst_n low, asynchronous): unknown state, indicators blank, contactor open,
// scanning off, holds at their default values, both registers empty.
`timescale 1ns / 1ps

module charge_session_controller_top import csc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	csc_in_if.sink    in_ch,
	csc_out_if.source out_ch,
	csc_cfg_if.sink   cfg
);

	csc_state_t              st_q;
	csc_state_t              st_nxt;
	csc_holds_t              holds_q;
	logic                    restart;

	logic                    valid_s1;
	logic [1:0]              rfid_s1;
	logic signed [CUR_W-1:0] cur_s1;

	logic                    valid_s2;
	logic                    relay_s2;
	logic                    scan_s2;
	logic [3:0]              pixel_s2;
	logic [1:0]              buzzer_s2;
	logic [CODE_W-1:0]       state_s2;
	logic                    restart_s2;

	logic                    advance;

	// Move a beat into the result register when it is empty or being drained
	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign cfg.ready   = 1'b1;

	// Hold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holds_q.deny  <= DENY_HOLD_RST;
			holds_q.auth  <= AUTH_HOLD_RST;
			holds_q.stage <= STAGE_HOLD_RST;
			holds_q.brief <= SHORT_HOLD_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DENY_HOLD:  holds_q.deny  <= cfg.data;
				REG_AUTH_HOLD:  holds_q.auth  <= cfg.data;
				REG_STAGE_HOLD: holds_q.stage <= cfg.data;
				REG_SHORT_HOLD: holds_q.brief <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			rfid_s1 <= in_ch.rfid_event;
			cur_s1  <= in_ch.load_current;
		end
	end

	csc_step u_step (
		.cur_st       (st_q),
		.holds        (holds_q),
		.rfid_event   (rfid_s1),
		.load_current (cur_s1),
		.nxt_st       (st_nxt),
		.restart      (restart)
	);

	// Controller state advances once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.main     <= ST_UNKNOWN;
			st_q.resume   <= ST_UNKNOWN;
			st_q.sub      <= SS_START;
			st_q.wait_rem <= '0;
			st_q.pending  <= EV_NONE;
			st_q.pixel    <= PIX_BLANK;
			st_q.buzzer   <= BUZ_OFF;
			st_q.relay    <= 1'b0;
			st_q.scan     <= 1'b0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			relay_s2   <= st_nxt.relay;
			scan_s2    <= st_nxt.scan;
			pixel_s2   <= st_nxt.pixel;
			buzzer_s2  <= st_nxt.buzzer;
			state_s2   <= state_code(st_nxt.main);
			restart_s2 <= restart;
		end
	end

	assign out_ch.valid         = valid_s2;
	assign out_ch.relay_on      = relay_s2;
	assign out_ch.scan_enable   = scan_s2;
	assign out_ch.pixel_code    = pixel_s2;
	assign out_ch.buzzer_code   = buzzer_s2;
	assign out_ch.session_state = state_s2;
	assign out_ch.pixel_restart = restart_s2;

endmodule

[bench/charge_session_controller_top_test.sv]
// Self-checking bench for the charging-point session controller: directed session walk,
// then random ticks checked against a cycle-free session predictor.
// Depends on csc_pkg, csc_ifs and charge_session_controller_top.
`timescale 1ns / 1ps

module charge_session_controller_top_test;
	import csc_pkg::*;

	localparam int unsigned LONG_STALL = 300;
	localparam int unsigned MAX_PRINTS = 40;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

	typedef struct packed {
		logic              relay;
		logic              scan;
		logic [3:0]        pixel;
		logic [1:0]        buzzer;
		logic [CODE_W-1:0] state;
		logic              restart;
	} tick_result_t;

	typedef struct {
		rfid_ev_t                ev;
		logic signed [CUR_W-1:0] cur;
		logic                    typed_in;
		tick_result_t            want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	csc_in_if  tick_ch ();
	csc_out_if result_ch ();
	csc_cfg_if reg_ch ();

	charge_session_controller_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (tick_ch),
		.out_ch (result_ch),
		.cfg    (reg_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Session predictor state and hold settings
	csc_holds_t hold_cfg = '{DENY_HOLD_RST, AUTH_HOLD_RST, STAGE_HOLD_RST, SHORT_HOLD_RST};
	logic [CODE_W-1:0] sess_code = CODE_UNKNOWN;
	logic [CODE_W-1:0] resume_code = CODE_UNKNOWN;
	sub_step_t         step = SS_START;
	logic [HOLD_W-1:0] hold_left = '0;
	rfid_ev_t          rfid_latched = EV_NONE;
	pixel_t            pix = PIX_BLANK;
	buzzer_t           buz = BUZ_OFF;
	logic              contactor = 1'b0;
	logic              scanning = 1'b0;

	tick_result_t due_outputs [$];
	plan_row_t    plan [$];
	int unsigned  mismatch_count = 0;
	int unsigned  results_seen = 0;
	int unsigned  send_gap_pct = 0;
	int unsigned  stall_pct = 0;
	logic         long_stall_req = 1'b0;
	logic         long_stall_done = 1'b0;

	function automatic void park(logic [CODE_W-1:0] next, logic [HOLD_W-1:0] hold);
		resume_code = next;
		sess_code = CODE_WAIT;
		hold_left = hold;
	endfunction

	// Advance the session by one millisecond tick and return the outputs it shows
	function automatic tick_result_t advance_session(rfid_ev_t ev, logic signed [CUR_W-1:0] cur);
		tick_result_t r;
		logic cur_zero;
		logic cur_pos;
		logic restart;
		cur_zero = (cur == '0);
		cur_pos = !cur_zero && !cur[CUR_W-1];
		restart = 1'b0;
		if (ev != EV_NONE)
			rfid_latched = ev;
		case (sess_code)
			CODE_ERROR: ;
			CODE_UNKNOWN: begin
				if (rfid_latched == EV_READER)
					sess_code = CODE_INIT;
			end
			CODE_INIT: begin
				sess_code = CODE_IDLE;
				contactor = 1'b0;
				scanning = 1'b1;
				step = SS_START;
			end
			CODE_IDLE: begin
				if (rfid_latched == EV_DENIED) begin
					pix = PIX_DENIED;
					buz = BUZ_DENIED;
					park(CODE_IDLE, hold_cfg.deny);
					rfid_latched = EV_NONE;
				end else if (rfid_latched == EV_AUTH) begin
					pix = PIX_AUTH;
					buz = BUZ_AUTH;
					step = SS_AUTH_IDLE;
					park(CODE_PREP, hold_cfg.auth);
					rfid_latched = EV_NONE;
				end else begin
					pix = PIX_IDLE;
				end
			end
			CODE_PREP: begin
				pix = PIX_PREP;
				scanning = 1'b0;
				step = SS_PREP;
				park(CODE_PRECHG, hold_cfg.stage);
				rfid_latched = EV_NONE;
			end
			CODE_PRECHG: begin
				if (step == SS_PREP) begin
					pix = PIX_PRECHG;
					step = SS_RELAY_ON;
					park(CODE_PRECHG, hold_cfg.stage);
					rfid_latched = EV_NONE;
					contactor = 1'b1;
				end else if (step == SS_RELAY_ON) begin
					if (!cur_zero) begin
						step = SS_SENSED;
						park(CODE_CHARGE, hold_cfg.brief);
						rfid_latched = EV_NONE;
						restart = 1'b1;
					end else begin
						// no current through the closed contactor: back to init
						contactor = 1'b0;
						sess_code = CODE_INIT;
						step = SS_NO_CURR;
					end
				end
			end
			CODE_CHARGE: begin
				scanning = 1'b1;
				if (cur_zero) begin
					if (step == SS_SENSED) begin
						step = SS_EV_DONE;
						pix = PIX_PRECHG;
						park(CODE_CHARGE, hold_cfg.stage);
					end else if (step == SS_EV_DONE) begin
						contactor = 1'b0;
						step = SS_RELAY_OFF;
						park(CODE_FINISH, hold_cfg.brief);
					end
				end else if (cur_pos) begin
					pix = PIX_CHARGE;
					if (rfid_latched == EV_DENIED) begin
						pix = PIX_DENIED;
						buz = BUZ_DENIED;
						park(CODE_CHARGE, hold_cfg.deny);
						rfid_latched = EV_NONE;
					end else if (rfid_latched == EV_AUTH) begin
						step = SS_AUTH_RUN;
						restart = 1'b1;
						pix = PIX_AUTH;
						buz = BUZ_AUTH;
						park(CODE_STOP, hold_cfg.auth);
						rfid_latched = EV_NONE;
						contactor = 1'b0;
					end
				end
			end
			CODE_STOP: begin
				pix = PIX_STOPPED;
				scanning = 1'b0;
				if (step == SS_AUTH_RUN) begin
					step = SS_USER_STOP;
					park(CODE_INIT, hold_cfg.stage);
				end
			end
			CODE_FINISH: begin
				pix = PIX_FINISH;
				if (step == SS_RELAY_OFF) begin
					step = SS_EV_FINAL;
					park(CODE_INIT, hold_cfg.stage);
				end
			end
			CODE_WAIT: begin
				if (hold_left > HOLD_W'(1)) begin
					hold_left = hold_left - HOLD_W'(1);
				end else begin
					// hold expired: blank the indicators and resume
					hold_left = '0;
					sess_code = resume_code;
					pix = PIX_BLANK;
					buz = BUZ_OFF;
				end
			end
			default: sess_code = CODE_UNKNOWN;
		endcase
		r.relay = contactor;
		r.scan = scanning;
		r.pixel = pix;
		r.buzzer = buz;
		r.state = sess_code;
		r.restart = restart;
		return r;
	endfunction

	function automatic plan_row_t fixed_row(rfid_ev_t ev, logic signed [CUR_W-1:0] cur,
			logic relay, logic scan, pixel_t pixel, buzzer_t buzzer,
			logic [CODE_W-1:0] state, logic restart);
		plan_row_t row;
		row.ev = ev;
		row.cur = cur;
		row.typed_in = 1'b1;
		row.want = '{relay, scan, pixel, buzzer, state, restart};
		return row;
	endfunction

	function automatic plan_row_t free_row(rfid_ev_t ev, logic signed [CUR_W-1:0] cur);
		plan_row_t row;
		row.ev = ev;
		row.cur = cur;
		row.typed_in = 1'b0;
		row.want = '0;
		return row;
	endfunction

	// Draw a current reading: zero, negative or positive, extremes now and then
	function automatic logic signed [CUR_W-1:0] draw_current(int unsigned zero_pct,
			int unsigned neg_pct);
		int unsigned roll;
		logic signed [CUR_W-1:0] v;
		roll = $urandom_range(99);
		if (roll < zero_pct)
			v = '0;
		else if (roll < zero_pct + neg_pct)
			v = {1'b1, 15'($urandom)};
		else
			v = {1'b0, 15'($urandom_range(32767, 1))};
		if (v != '0) begin
			roll = $urandom_range(19);
			if (roll == 0)
				v = {v[CUR_W-1], {(CUR_W-1){~v[CUR_W-1]}}};
			else if (roll == 1)
				v = v[CUR_W-1] ? '1 : 16'sd1;
		end
		return v;
	endfunction

	// Pick the next tick from where the session stands; some ticks are plain noise
	function automatic void choose_tick(output rfid_ev_t ev, output logic signed [CUR_W-1:0] cur);
		int unsigned roll;
		roll = $urandom_range(99);
		ev = EV_NONE;
		cur = draw_current(20, 20);
		if (roll < 15) begin
			ev = rfid_ev_t'(2'($urandom_range(3)));
			cur = draw_current(30, 30);
			return;
		end
		case (sess_code)
			CODE_UNKNOWN: if (roll < 70) ev = EV_READER;
			CODE_IDLE: begin
				if (roll < 55)
					ev = EV_AUTH;
				else if (roll < 75)
					ev = EV_DENIED;
			end
			CODE_PRECHG: cur = draw_current(15, 20);
			CODE_CHARGE: begin
				cur = draw_current(8, 8);
				if (roll > 95)
					ev = EV_AUTH;
				else if (roll > 91)
					ev = EV_DENIED;
			end
			default: ;
		endcase
	endfunction

	task automatic log_mismatch(string msg);
		if (mismatch_count < MAX_PRINTS)
			$display("[%0t] mismatch at result beat %0d: %s", $time, results_seen, msg);
		mismatch_count++;
	endtask

	// Offer one tick beat, with random gaps ahead of it, and log its expected outputs
	task automatic offer_tick(rfid_ev_t ev, logic signed [CUR_W-1:0] cur, logic typed_in,
			tick_result_t want);
		tick_result_t predicted;
		while ($urandom_range(99) < send_gap_pct) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.rfid_event <= ev;
		tick_ch.load_current <= cur;
		do begin
			@(posedge clk);
		end while (!tick_ch.ready);
		predicted = advance_session(ev, cur);
		due_outputs.push_back(typed_in ? want : predicted);
	endtask

	// Drop valid and hold until every expected beat has come back
	task automatic settle();
		tick_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (due_outputs.size() != 0);
	endtask

	// Write all four holds back to back; optionally poke indexes that do not exist
	task automatic load_holds(csc_holds_t h, logic poke_unused);
		logic [CFG_IDX_W-1:0] idx [$];
		logic [HOLD_W-1:0]    val [$];
		idx = {REG_DENY_HOLD, REG_AUTH_HOLD, REG_STAGE_HOLD, REG_SHORT_HOLD};
		val = {h.deny, h.auth, h.stage, h.brief};
		if (poke_unused) begin
			idx.push_back(REG_UNUSED_LO);
			val.push_back(HOLD_W'($urandom_range(65535, 1)));
			idx.push_back(REG_UNUSED_HI);
			val.push_back('0);
		end
		foreach (idx[i]) begin
			reg_ch.valid <= 1'b1;
			reg_ch.index <= idx[i];
			reg_ch.data <= val[i];
			do begin
				@(posedge clk);
			end while (!reg_ch.ready);
			case (idx[i])
				REG_DENY_HOLD:  hold_cfg.deny = val[i];
				REG_AUTH_HOLD:  hold_cfg.auth = val[i];
				REG_STAGE_HOLD: hold_cfg.stage = val[i];
				REG_SHORT_HOLD: hold_cfg.brief = val[i];
				default: ;
			endcase
		end
		reg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(int unsigned n_ticks, int unsigned gap_pct, int unsigned stall,
			logic long_stall, logic mid_pause);
		rfid_ev_t ev;
		logic signed [CUR_W-1:0] cur;
		send_gap_pct = gap_pct;
		stall_pct = stall;
		if (long_stall)
			long_stall_req = 1'b1;
		for (int k = 0; k < n_ticks; k++) begin
			if (mid_pause && k == n_ticks / 2)
				settle();
			choose_tick(ev, cur);
			offer_tick(ev, cur, 1'b0, '0);
		end
		settle();
	endtask

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_stall_req && !long_stall_done) begin
				long_stall_done = 1'b1;
				for (int n = 0; n < LONG_STALL; n++) begin
					result_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Compare every result beat with the oldest expectation
	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (due_outputs.size() == 0) begin
				log_mismatch("result beat with nothing expected");
			end else begin
				want = due_outputs.pop_front();
				if (result_ch.relay_on !== want.relay)
					log_mismatch($sformatf("relay_on %b, want %b", result_ch.relay_on, want.relay));
				if (result_ch.scan_enable !== want.scan)
					log_mismatch($sformatf("scan_enable %b, want %b",
						result_ch.scan_enable, want.scan));
				if (result_ch.pixel_code !== want.pixel)
					log_mismatch($sformatf("pixel_code %0d, want %0d",
						result_ch.pixel_code, want.pixel));
				if (result_ch.buzzer_code !== want.buzzer)
					log_mismatch($sformatf("buzzer_code %0d, want %0d",
						result_ch.buzzer_code, want.buzzer));
				if (result_ch.session_state !== want.state)
					log_mismatch($sformatf("session_state %0d, want %0d",
						result_ch.session_state, want.state));
				if (result_ch.pixel_restart !== want.restart)
					log_mismatch($sformatf("pixel_restart %b, want %b",
						result_ch.pixel_restart, want.restart));
			end
			results_seen++;
		end
	end

	initial begin
		#2_400_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		tick_ch.valid <= 1'b0;
		tick_ch.rfid_event <= EV_NONE;
		tick_ch.load_current <= '0;
		reg_ch.valid <= 1'b0;
		reg_ch.index <= REG_DENY_HOLD;
		reg_ch.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Shortest holds, then walk a session: reader, denied card, authorized card,
		// precharge without current, a second run through charging into user stop
		load_holds(csc_holds_t'{16'd1, 16'd1, 16'd1, 16'd1}, 1'b0);
		plan = {
			fixed_row(EV_NONE, 16'sh8000, 1'b0, 1'b0, PIX_BLANK, BUZ_OFF, CODE_UNKNOWN, 1'b0),
			fixed_row(EV_READER, 16'sh7FFF, 1'b0, 1'b0, PIX_BLANK, BUZ_OFF, CODE_INIT, 1'b0),
			fixed_row(EV_NONE, 16'sd0, 1'b0, 1'b1, PIX_BLANK, BUZ_OFF, CODE_IDLE, 1'b0),
			fixed_row(EV_NONE, 16'sd0, 1'b0, 1'b1, PIX_IDLE, BUZ_OFF, CODE_IDLE, 1'b0),
			fixed_row(EV_DENIED, 16'sd0, 1'b0, 1'b1, PIX_DENIED, BUZ_DENIED, CODE_WAIT, 1'b0),
			fixed_row(EV_NONE, 16'sd0, 1'b0, 1'b1, PIX_BLANK, BUZ_OFF, CODE_IDLE, 1'b0),
			fixed_row(EV_AUTH, 16'sd0, 1'b0, 1'b1, PIX_AUTH, BUZ_AUTH, CODE_WAIT, 1'b0),
			fixed_row(EV_NONE, 16'sd0, 1'b0, 1'b1, PIX_BLANK, BUZ_OFF, CODE_PREP, 1'b0),
			fixed_row(EV_NONE, 16'sd0, 1'b0, 1'b0, PIX_PREP, BUZ_OFF, CODE_WAIT, 1'b0),
			fixed_row(EV_NONE, 16'sd0, 1'b0, 1'b0, PIX_BLANK, BUZ_OFF, CODE_PRECHG, 1'b0),
			fixed_row(EV_NONE, 16'sd0, 1'b1, 1'b0, PIX_PRECHG, BUZ_OFF, CODE_WAIT, 1'b0),
			fixed_row(EV_NONE, 16'sd0, 1'b1, 1'b0, PIX_BLANK, BUZ_OFF, CODE_PRECHG, 1'b0),
			fixed_row(EV_NONE, 16'sd0, 1'b0, 1'b0, PIX_BLANK, BUZ_OFF, CODE_INIT, 1'b0),
			fixed_row(EV_NONE, 16'sd0, 1'b0, 1'b1, PIX_BLANK, BUZ_OFF, CODE_IDLE, 1'b0),
			free_row(EV_AUTH,   16'sd0),
			free_row(EV_NONE,   -16'sd1),
			free_row(EV_NONE,   16'sd0),
			free_row(EV_NONE,   16'sd0),
			free_row(EV_NONE,   16'sd0),
			free_row(EV_NONE,   16'sd0),
			free_row(EV_NONE,   16'sd1),
			free_row(EV_NONE,   16'sd0),
			free_row(EV_DENIED, 16'sh7FFF),
			free_row(EV_NONE,   16'sd0),
			free_row(EV_NONE,   16'sh8000),
			free_row(EV_AUTH,   16'sd100),
			free_row(EV_NONE,   16'sd0)
		};
		foreach (plan[i])
			offer_tick(plan[i].ev, plan[i].cur, plan[i].typed_in, plan[i].want);
		settle();

		// Random sessions under several hold settings and idling patterns
		load_holds(csc_holds_t'{16'd1, 16'd2, 16'd3, 16'd1}, 1'b0);
		run_phase(150, 0, 0, 1'b0, 1'b0);
		load_holds(csc_holds_t'{16'd5, 16'd7, 16'd9, 16'd2}, 1'b0);
		run_phase(150, 75, 0, 1'b0, 1'b1);
		load_holds(csc_holds_t'{16'd1, 16'd1, 16'd1, 16'd1}, 1'b0);
		run_phase(150, 0, 75, 1'b1, 1'b0);
		load_holds(csc_holds_t'{16'd40, 16'd2, 16'd120, 16'd3}, 1'b0);
		run_phase(200, 16, 16, 1'b0, 1'b0);
		load_holds(csc_holds_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1);
		run_phase(60, 16, 16, 1'b0, 1'b0);

		// Catch any stray beat after the last expected one
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
rtl/csc_pkg.sv
rtl/csc_ifs.sv
rtl/csc_step.sv
rtl/charge_session_controller_top.sv
bench/charge_session_controller_top_test.sv
